// File: hdl/rstack_pkg.sv
package rstack_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int ID_W            = 16;
  localparam int DOORS_W         = 4;
  localparam int PRICE_W         = 24;
  localparam int HANDLE_W        = 32;
  localparam int SERIES_W        = 8;
  localparam int COUNT_W         = 5;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_TAKE = 2'd2,
    CMD_AVG  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_OVF,
    RES_REC,
    RES_AVG
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RD,
    S_POP_HIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [DOORS_W-1:0]  doors;
    logic [PRICE_W-1:0]  price;
    logic [HANDLE_W-1:0] model;
    logic [HANDLE_W-1:0] driver;
    logic [SERIES_W-1:0] series;
  } rec_t;

  typedef struct packed {
    logic      latch;
    logic      push_wr;
    logic      idx_top;
    logic      idx_dec;
    logic      idx_inc;
    logic      rd_en;
    logic      rd_next;
    logic      shift_wr;
    logic      hit_take;
    logic      div_start;
    logic      div_step;
    logic      load_out;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t op_cmd;
    logic full;
    logic empty;
    logic key_match;
    logic idx_zero;
    logic idx_below_cnt;
    logic div_last;
  } dp_sts_t;

endpackage

// File: hdl/rstack_dp.sv
module rstack_dp
  import rstack_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [1:0]          in_cmd,
  input  logic [ID_W-1:0]     in_car_id,
  input  logic [DOORS_W-1:0]  in_door_count,
  input  logic [PRICE_W-1:0]  in_price_cents,
  input  logic [HANDLE_W-1:0] in_model_handle,
  input  logic [HANDLE_W-1:0] in_driver_handle,
  input  logic [SERIES_W-1:0] in_series_char,
  output logic                out_found,
  output logic                out_overflow,
  output logic [ID_W-1:0]     out_id,
  output logic [DOORS_W-1:0]  out_doors,
  output logic [PRICE_W-1:0]  out_price,
  output logic [HANDLE_W-1:0] out_model,
  output logic [HANDLE_W-1:0] out_driver,
  output logic [SERIES_W-1:0] out_series,
  output logic [COUNT_W-1:0]  out_entry_count,
  output logic [PRICE_W-1:0]  out_average_price
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SW  = PRICE_W + AW;
  localparam int STW = $clog2(SW);

  rec_t mem [STACK_DEPTH];

  cmd_t            op_cmd_r;
  logic [ID_W-1:0] op_key_r;
  rec_t            op_rec_r;
  rec_t            rd_data_r;
  rec_t            hit_rec_r;
  logic [AW-1:0]   idx_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [SW-1:0]   sum_r, sum_nxt;
  logic [SW-1:0]   quo_r;
  logic [CW-1:0]   rem_r;
  logic [STW-1:0]  step_r;

  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  rec_t            wr_data;
  logic            wr_en;
  logic [CW:0]     div_sh;
  logic [CW:0]     div_diff;
  logic            div_ge;
  logic [CW+4:0]   cnt_ext;

  assign cnt_m1   = cnt_r - CW'(1);
  assign rd_addr  = cmd.rd_next ? idx_r + AW'(1) : idx_r;
  assign wr_en    = cmd.push_wr | cmd.shift_wr;
  assign wr_addr  = cmd.push_wr ? cnt_r[AW-1:0] : idx_r;
  assign wr_data  = cmd.push_wr ? op_rec_r : rd_data_r;
  assign div_sh   = {rem_r, quo_r[SW-1]};
  assign div_diff = div_sh - {1'b0, cnt_r};
  assign div_ge   = (div_sh >= {1'b0, cnt_r});
  assign cnt_ext  = {5'b0, cnt_r};

  always_comb begin
    sts.op_cmd        = op_cmd_r;
    sts.full          = (cnt_r == CW'(STACK_DEPTH));
    sts.empty         = (cnt_r == '0);
    sts.key_match     = (rd_data_r.id == op_key_r);
    sts.idx_zero      = (idx_r == '0);
    sts.idx_below_cnt = (CW'(idx_r) < cnt_r);
    sts.div_last      = (step_r == STW'(SW - 1));
  end

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (cmd.push_wr) begin
      cnt_nxt = cnt_r + CW'(1);
      sum_nxt = sum_r + SW'(op_rec_r.price);
    end else if (cmd.hit_take) begin
      cnt_nxt = cnt_m1;
      sum_nxt = sum_r - SW'(rd_data_r.price);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  // record memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_cmd_r        <= cmd_t'(in_cmd);
      op_key_r        <= in_car_id;
      op_rec_r.id     <= in_car_id;
      op_rec_r.doors  <= in_door_count;
      op_rec_r.price  <= in_price_cents;
      op_rec_r.model  <= in_model_handle;
      op_rec_r.driver <= in_driver_handle;
      op_rec_r.series <= in_series_char;
    end
    if (cmd.idx_top) begin
      idx_r <= cnt_m1[AW-1:0];
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - AW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.hit_take) begin
      hit_rec_r <= rd_data_r;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r  <= sum_r;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[SW-2:0], div_ge};
      rem_r  <= div_ge ? div_diff[CW-1:0] : div_sh[CW-1:0];
      step_r <= step_r + STW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found         <= (cmd.res_kind == RES_REC);
      out_overflow      <= (cmd.res_kind == RES_OVF);
      out_entry_count   <= cnt_ext[COUNT_W-1:0];
      out_average_price <= (cmd.res_kind == RES_AVG) ? quo_r[PRICE_W-1:0] : '0;
      if (cmd.res_kind == RES_REC) begin
        out_id     <= hit_rec_r.id;
        out_doors  <= hit_rec_r.doors;
        out_price  <= hit_rec_r.price;
        out_model  <= hit_rec_r.model;
        out_driver <= hit_rec_r.driver;
        out_series <= hit_rec_r.series;
      end else begin
        out_id     <= '0;
        out_doors  <= '0;
        out_price  <= '0;
        out_model  <= '0;
        out_driver <= '0;
        out_series <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_sum_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (sum_r == '0))
    else $error("price sum nonzero on empty stack");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !sts.full)
    else $error("push written into full stack");
`endif

endmodule

// File: hdl/rstack_ctrl.sv
module rstack_ctrl
  import rstack_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;
  logic      out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= RES_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.res_kind  = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        kind_nxt  = RES_NONE;
        state_nxt = S_FINISH;
        case (sts.op_cmd)
          CMD_PUSH: begin
            if (sts.full) begin
              kind_nxt = RES_OVF;
            end else begin
              cmd.push_wr = 1'b1;
            end
          end
          CMD_POP: begin
            if (!sts.empty) begin
              cmd.idx_top = 1'b1;
              state_nxt   = S_POP_RD;
            end
          end
          CMD_TAKE: begin
            if (!sts.empty) begin
              cmd.idx_top = 1'b1;
              state_nxt   = S_SCAN_RD;
            end
          end
          CMD_AVG: begin
            if (!sts.empty) begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_POP_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_POP_HIT;
      end
      S_POP_HIT: begin
        cmd.hit_take = 1'b1;
        kind_nxt     = RES_REC;
        state_nxt    = S_FINISH;
      end
      S_SCAN_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.key_match) begin
          cmd.hit_take = 1'b1;
          kind_nxt     = RES_REC;
          state_nxt    = S_SHIFT_RD;
        end else if (sts.idx_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      // close the gap left by the removed record
      S_SHIFT_RD: begin
        if (sts.idx_below_cnt) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_SHIFT_WR;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          kind_nxt  = RES_AVG;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted request not decoded");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.load_out)
    else $error("pending result overwritten");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !sts.div_last) |=> (state_r == S_DIV))
    else $error("divide left early");
`endif

endmodule

// File: hdl/record_stack_with_keyed_removal.sv
// channel  | handshake            | payload
// in       | in_valid / in_ready  | in_cmd, in_car_id, in_door_count, in_price_cents,
//          |                      | in_model_handle, in_driver_handle, in_series_char
// out      | out_valid / out_ready| out_found, out_overflow, out_id .. out_average_price
//
// one request at a time; push, and any request on an empty stack, ends after decode; pop
// reads the top record; take by id compares records from the top down and on a hit moves
// the records above down a slot; average divides sum by count, one quotient bit per cycle
// a finished result waits in the output register while the next request is taken
// the last cycle of a request repeats while the output register holds an unaccepted result
// synchronous active-low reset empties the stack; record memory is not cleared
module record_stack_with_keyed_removal
  import rstack_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [ID_W-1:0]     in_car_id,
  input  logic [DOORS_W-1:0]  in_door_count,
  input  logic [PRICE_W-1:0]  in_price_cents,
  input  logic [HANDLE_W-1:0] in_model_handle,
  input  logic [HANDLE_W-1:0] in_driver_handle,
  input  logic [SERIES_W-1:0] in_series_char,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic                out_overflow,
  output logic [ID_W-1:0]     out_id,
  output logic [DOORS_W-1:0]  out_doors,
  output logic [PRICE_W-1:0]  out_price,
  output logic [HANDLE_W-1:0] out_model,
  output logic [HANDLE_W-1:0] out_driver,
  output logic [SERIES_W-1:0] out_series,
  output logic [COUNT_W-1:0]  out_entry_count,
  output logic [PRICE_W-1:0]  out_average_price
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  rstack_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  rstack_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .sts               (dp_sts),
    .in_cmd            (in_cmd),
    .in_car_id         (in_car_id),
    .in_door_count     (in_door_count),
    .in_price_cents    (in_price_cents),
    .in_model_handle   (in_model_handle),
    .in_driver_handle  (in_driver_handle),
    .in_series_char    (in_series_char),
    .out_found         (out_found),
    .out_overflow      (out_overflow),
    .out_id            (out_id),
    .out_doors         (out_doors),
    .out_price         (out_price),
    .out_model         (out_model),
    .out_driver        (out_driver),
    .out_series        (out_series),
    .out_entry_count   (out_entry_count),
    .out_average_price (out_average_price)
  );

endmodule
